@@ src/rk4_ode_stepper_core_assert.svh @@
// ----------------------------------------------------------------------------
// rk4_ode_stepper_core assertion macros
// Shared assertion forms for the stepper modules; they expect clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef RK4_ODE_STEPPER_CORE_ASSERT_SVH
`define RK4_ODE_STEPPER_CORE_ASSERT_SVH

// same-cycle implication
`define RK4_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RK4_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rk4_pkg.sv @@
// ----------------------------------------------------------------------------
// rk4_pkg
// Types, codes and the Q16.16 saturation helper shared by the stepper.
// ----------------------------------------------------------------------------
package rk4_pkg;

	localparam int QW     = 32;
	localparam int HW     = 31;
	localparam int CNT_W  = 16;
	localparam int SUM_W  = 35;
	localparam int DIV_W  = 34;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_EQ_SEL  = 3'd0;
	localparam logic [IDX_W-1:0] REG_STEP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_START = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_START = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd4;

	localparam logic [1:0] EQ_X_PLUS_Y  = 2'd0;
	localparam logic [1:0] EQ_TWO_X     = 2'd1;
	localparam logic [1:0] EQ_THREE_M_Y = 2'd2;
	localparam logic [1:0] EQ_NEG_Y     = 2'd3;

	localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
	localparam logic signed [63:0] Q_THREE = 64'sd196608;
	localparam logic signed [63:0] RND_HALF = 64'sd32768;

	typedef struct packed {
		logic signed [QW-1:0] val;
		logic                 sat;
	} q_clip_t;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic                 sat;
	} step_res_t;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic                 lim;
		logic                 sat;
	} out_item_t;

	typedef enum logic {
		TOP_IDLE,
		TOP_RUN
	} top_state_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DERIV,
		SQ_MUL,
		SQ_ROUND,
		SQ_DIVGO,
		SQ_DIVW,
		SQ_DONE
	} sq_state_t;

	function automatic q_clip_t q_clip(input logic signed [63:0] v);
		q_clip_t r;
		if (v > Q_MAX64) begin
			r.val = Q_MAX64[QW-1:0];
			r.sat = 1'b1;
		end else if (v < Q_MIN64) begin
			r.val = Q_MIN64[QW-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = v[QW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ src/rk4_ode_stepper_core.sv @@
// ----------------------------------------------------------------------------
// rk4_ode_stepper_core: Q16.16 fourth-order Runge-Kutta stepper
// A step request makes four derivative/multiply/round passes through one
// multiplier, then a divide by six. No new request is taken while a step runs,
// nor while a result waits that the output side does not take. Restart and held
// requests return without a step. Async reset loads the default registers.
// ----------------------------------------------------------------------------
`include "rk4_ode_stepper_core_assert.svh"

module rk4_ode_stepper_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rk4_pkg::IDX_W-1:0]    cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [0] restart, [7:1] zero
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [71:0]                  m_tdata   // [31:0] x_now, [63:32] y_now,
	                                               // [64] limit_reached, [65] saturated
);
	import rk4_pkg::*;

	logic [1:0]           eq_q;
	logic [HW-1:0]        h_q;
	logic signed [QW-1:0] xs_q, ys_q, x_cur_q, y_cur_q;
	logic [CNT_W-1:0]     lim_q, steps_q, steps_inc;

	top_state_t st_q, st_d;
	out_item_t  out_q;
	logic       out_v_q;

	logic acc, restart, can_step, seq_start, seq_done;
	step_res_t seq_res;

	assign acc       = s_tvalid && s_tready;
	assign restart   = s_tdata[0];
	assign can_step  = (steps_q < lim_q);
	assign steps_inc = steps_q + CNT_W'(1);

	rk4_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.eq_sel (eq_q),
		.h      (h_q),
		.x_in   (x_cur_q),
		.y_in   (y_cur_q),
		.done   (seq_done),
		.res    (seq_res)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			TOP_IDLE: if (acc && !restart && can_step) st_d = TOP_RUN;
			TOP_RUN:  if (seq_done) st_d = TOP_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (st_q == TOP_IDLE) && (!out_v_q || m_tready);
		seq_start = acc && !restart && can_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_q    <= EQ_X_PLUS_Y;
			h_q     <= HW'(6554);
			xs_q    <= '0;
			ys_q    <= 32'sd65536;
			lim_q   <= CNT_W'(20);
			x_cur_q <= '0;
			y_cur_q <= 32'sd65536;
			steps_q <= '0;
			st_q    <= TOP_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EQ_SEL:  eq_q  <= cfg_data[1:0];
					REG_STEP:    h_q   <= cfg_data[HW-1:0];
					REG_X_START: xs_q  <= cfg_data;
					REG_Y_START: ys_q  <= cfg_data;
					REG_LIMIT:   lim_q <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (acc && restart) begin
				x_cur_q <= xs_q;
				y_cur_q <= ys_q;
				steps_q <= '0;
			end else if (seq_done) begin
				x_cur_q <= seq_res.x;
				y_cur_q <= seq_res.y;
				steps_q <= steps_inc;
			end
			if ((acc && (restart || !can_step)) || seq_done) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && restart) begin
			out_q <= '{x: xs_q, y: ys_q, lim: (lim_q == '0), sat: 1'b0};
		end else if (acc && !can_step) begin
			out_q <= '{x: x_cur_q, y: y_cur_q, lim: 1'b1, sat: 1'b0};
		end else if (seq_done) begin
			out_q <= '{x: seq_res.x, y: seq_res.y, lim: (steps_inc >= lim_q),
				sat: seq_res.sat};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, out_q.sat, out_q.lim, out_q.y, out_q.x};

	`RK4_ASSERT_IMP(a_done_in_run, seq_done, st_q == TOP_RUN, "step done while idle")
	`RK4_ASSERT_IMP(a_out_free_run, st_q == TOP_RUN, !out_v_q, "result pending during step")
	`RK4_ASSERT_NXT(a_step_count, seq_done, steps_q == $past(steps_inc), "step count missed")

endmodule

@@ src/rk4_mul.sv @@
// ----------------------------------------------------------------------------
// rk4_mul
// Shared registered multiplier: step size times a Q16.16 derivative.
// ----------------------------------------------------------------------------
module rk4_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rk4_pkg::HW-1:0]      a,
	input  logic signed [rk4_pkg::QW-1:0] b,
	output logic signed [62:0]          prod
);
	import rk4_pkg::*;

	logic signed [63:0] full;
	logic signed [62:0] prod_s1;

	assign full = $signed({1'b0, a}) * b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= full[62:0];
		end
	end

	assign prod = prod_s1;

endmodule

@@ src/rk4_div6.sv @@
// ----------------------------------------------------------------------------
// rk4_div6
// Divider by six: reciprocal multiply on 17-bit digits, high first.
// ----------------------------------------------------------------------------
module rk4_div6 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rk4_pkg::DIV_W-1:0]  n,
	output logic [rk4_pkg::DIV_W-1:0]  q,
	output logic                       done
);
	import rk4_pkg::*;

	localparam int CH_W = DIV_W / 2;
	localparam int PW   = CH_W + 3;
	localparam int RW   = CH_W + 3;
	localparam int RSH  = CH_W + 5;
	// ceil(2^22 / 6); exact floor for every partial dividend below 2^21
	localparam logic [RW-1:0] RECIP = RW'((2**RSH + 5) / 6);
	localparam logic [1:0]    N_CH  = 2'd2;

	logic [2:0]       rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [1:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PW-1:0]    part;
	logic [PW+RW-1:0] prod;
	logic [CH_W-1:0]  qdig;
	logic [PW-1:0]    back;
	logic [PW-1:0]    diff;

	// remainder so far joined to the top unconsumed digit
	assign part = {rem_q, quo_q[DIV_W-1 -: CH_W]};
	assign prod = part * RECIP;
	assign qdig = prod[RSH +: CH_W];
	assign back = PW'({qdig, 2'b00}) + PW'({qdig, 1'b0});
	assign diff = part - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= N_CH;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 2'd1;
				if (cnt_q == 2'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
		end else if (busy_q) begin
			rem_q <= diff[2:0];
			quo_q <= {quo_q[DIV_W-CH_W-1:0], qdig};
		end
	end

	assign q    = quo_q;
	assign done = done_q;

endmodule

@@ src/rk4_seq.sv @@
// ----------------------------------------------------------------------------
// rk4_seq
// Step sequencer: four derivative/multiply/round passes, then weighted sum / 6.
// ----------------------------------------------------------------------------
`include "rk4_ode_stepper_core_assert.svh"

module rk4_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    eq_sel,
	input  logic [rk4_pkg::HW-1:0]        h,
	input  logic signed [rk4_pkg::QW-1:0] x_in,
	input  logic signed [rk4_pkg::QW-1:0] y_in,
	output logic                          done,
	output rk4_pkg::step_res_t            res
);
	import rk4_pkg::*;

	sq_state_t st_q, st_d;
	logic [1:0] kidx_q;

	logic signed [QW-1:0]    x_q, y_q, xm_q, xe_q, yarg_q, f_q, ynew_q;
	logic signed [SUM_W-1:0] s_q;
	logic                    sat_q;

	logic mul_en, div_start, div_done;
	logic signed [62:0]    prod;
	logic [DIV_W-1:0]      div_q;
	logic [DIV_W-1:0]      div_n;
	logic signed [SUM_W-1:0] s_abs;

	logic signed [QW-1:0] xarg;
	logic signed [63:0]   f_raw, k_raw, ynext_raw, d64;
	q_clip_t cm, ce, cf, ck, cy, cd, cyn;
	logic signed [SUM_W-1:0] k_w;

	rk4_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (h),
		.b    (f_q),
		.prod (prod)
	);

	rk4_div6 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.q      (div_q),
		.done   (div_done)
	);

	// stage arguments
	assign cm = q_clip(64'(x_in) + $signed(64'(h >> 1)));
	assign ce = q_clip(64'(x_in) + $signed(64'(h)));

	always_comb begin
		if (kidx_q == 2'd0) begin
			xarg = x_q;
		end else if (kidx_q == 2'd3) begin
			xarg = xe_q;
		end else begin
			xarg = xm_q;
		end
		unique case (eq_sel)
			EQ_X_PLUS_Y:  f_raw = 64'(xarg) + 64'(yarg_q);
			EQ_TWO_X:     f_raw = 64'(xarg) + 64'(xarg);
			EQ_THREE_M_Y: f_raw = Q_THREE - 64'(yarg_q);
			EQ_NEG_Y:     f_raw = -64'(yarg_q);
		endcase
	end
	assign cf = q_clip(f_raw);

	assign k_raw = (64'(prod) + RND_HALF) >>> 16;
	assign ck    = q_clip(k_raw);
	assign k_w   = SUM_W'(ck.val);

	always_comb begin
		if (kidx_q == 2'd2) begin
			ynext_raw = 64'(y_q) + 64'(ck.val);
		end else begin
			ynext_raw = 64'(y_q) + (64'(ck.val) >>> 1);
		end
	end
	assign cy = q_clip(ynext_raw);

	assign s_abs = s_q[SUM_W-1] ? -s_q : s_q;
	assign div_n = s_abs[DIV_W-1:0] + DIV_W'(3);

	always_comb begin
		if (s_q[SUM_W-1]) begin
			d64 = -$signed({{(64-DIV_W){1'b0}}, div_q});
		end else begin
			d64 = $signed({{(64-DIV_W){1'b0}}, div_q});
		end
	end
	assign cd  = q_clip(d64);
	assign cyn = q_clip(64'(y_q) + 64'(cd.val));

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SQ_IDLE:  if (start) st_d = SQ_DERIV;
			SQ_DERIV: st_d = SQ_MUL;
			SQ_MUL:   st_d = SQ_ROUND;
			SQ_ROUND: st_d = (kidx_q == 2'd3) ? SQ_DIVGO : SQ_DERIV;
			SQ_DIVGO: st_d = SQ_DIVW;
			SQ_DIVW:  if (div_done) st_d = SQ_DONE;
			SQ_DONE:  st_d = SQ_IDLE;
			default:  st_d = SQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mul_en    = (st_q == SQ_MUL);
		div_start = (st_q == SQ_DIVGO);
		done      = (st_q == SQ_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SQ_IDLE;
			kidx_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == SQ_IDLE) begin
				kidx_q <= '0;
			end else if (st_q == SQ_ROUND) begin
				kidx_q <= kidx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			SQ_IDLE: begin
				if (start) begin
					x_q    <= x_in;
					y_q    <= y_in;
					yarg_q <= y_in;
					xm_q   <= cm.val;
					xe_q   <= ce.val;
					sat_q  <= cm.sat | ce.sat;
					s_q    <= '0;
				end
			end
			SQ_DERIV: begin
				f_q   <= cf.val;
				sat_q <= sat_q | cf.sat;
			end
			SQ_ROUND: begin
				if (kidx_q == 2'd1 || kidx_q == 2'd2) begin
					s_q <= s_q + (k_w <<< 1);
				end else begin
					s_q <= s_q + k_w;
				end
				if (kidx_q != 2'd3) begin
					yarg_q <= cy.val;
					sat_q  <= sat_q | ck.sat | cy.sat;
				end else begin
					sat_q <= sat_q | ck.sat;
				end
			end
			SQ_DIVW: begin
				if (div_done) begin
					ynew_q <= cyn.val;
					sat_q  <= sat_q | cd.sat | cyn.sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.x   = xe_q;
	assign res.y   = ynew_q;
	assign res.sat = sat_q;

	`RK4_ASSERT_IMP(a_div_done_wait, div_done, st_q == SQ_DIVW, "divider done outside wait")
	`RK4_ASSERT_IMP(a_div_after_four, st_q == SQ_DIVGO, kidx_q == 2'd0, "sum taken early")
	`RK4_ASSERT_IMP(a_start_idle, start, st_q == SQ_IDLE, "step started while busy")

endmodule

@@ tb/rk4_ode_stepper_core_tb.sv @@
// ----------------------------------------------------------------------------
// rk4_ode_stepper_core_tb: self-checking bench for the RK4 stepper core
// Runs a directed table first: reset state, hold at the step limit, a lowered
// limit, zero step size, saturation at the Q16.16 extremes, every equation and
// spare register indexes. Then random restart/step runs under random register
// settings. Each result is checked against a bit-exact Q16.16 RK4 integrator
// in the bench or a typed table value, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module rk4_ode_stepper_core_tb;
	import rk4_pkg::*;

	typedef struct packed {
		logic        sat;
		logic        lim;
		logic [31:0] y;
		logic [31:0] x;
	} xy_res_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [31:0]      data;
		logic             restart;
		logic             typed;
		xy_res_t          want;
	} plan_row_t;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam longint THREE_Q = 64'sd196608;
	localparam logic [31:0] Q_HI = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_LO = 32'h8000_0000;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;
	localparam logic [IDX_W-1:0] REG_SPARE = REG_LIMIT + 1'b1;
	localparam int ITEM_COUNT = 600;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0]      cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [71:0]      m_tdata;

	// tag carried beside a directed request whose result is typed in the table
	logic    item_typed = 1'b0;
	xy_res_t item_want = '0;

	// bench copy of the registers and the integrator state
	logic [1:0]         eq_sel = EQ_X_PLUS_Y;
	logic [30:0]        h_step = 31'd6554;
	logic signed [31:0] x_init = '0;
	logic signed [31:0] y_init = ONE_Q;
	logic [15:0]        step_cap = 16'd20;
	logic signed [31:0] x_cur = '0;
	logic signed [31:0] y_cur = ONE_Q;
	logic [15:0]        step_count = '0;
	logic               clipped;

	xy_res_t   expected_xy[$];
	plan_row_t plan[$];
	int        errors = 0;
	int        idle_pct = 9;
	logic      quiet = 1'b0;

	rk4_ode_stepper_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),  // [0] restart, [7:1] zero
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)   // [31:0] x_now, [63:32] y_now, [64] limit_reached,
		                      // [65] saturated, [71:66] zero
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 9);
	end

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > SAT_HI) begin
			clipped = 1'b1;
			return Q_HI;
		end
		if (v < SAT_LO) begin
			clipped = 1'b1;
			return Q_LO;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] slope(input logic signed [31:0] x,
			input logic signed [31:0] y);
		case (eq_sel)
			EQ_X_PLUS_Y:  return sat32(longint'(x) + longint'(y));
			EQ_TWO_X:     return sat32(2 * longint'(x));
			EQ_THREE_M_Y: return sat32(THREE_Q - longint'(y));
			default:      return sat32(-longint'(y));
		endcase
	endfunction

	function automatic logic signed [31:0] scale_by_h(input logic signed [31:0] f);
		longint p;
		p = longint'(h_step) * longint'(f);
		return sat32((p + 64'sd32768) >>> 16);
	endfunction

	function automatic xy_res_t rk4_integrate(input logic restart);
		longint             h, s, d;
		logic signed [31:0] xm, xe, k1, k2, k3, k4;
		xy_res_t            r;
		clipped = 1'b0;
		if (restart) begin
			x_cur = x_init;
			y_cur = y_init;
			step_count = '0;
		end else if (step_count < step_cap) begin
			h = longint'(h_step);
			xm = sat32(longint'(x_cur) + (h >>> 1));
			xe = sat32(longint'(x_cur) + h);
			k1 = scale_by_h(slope(x_cur, y_cur));
			k2 = scale_by_h(slope(xm, sat32(longint'(y_cur) + (longint'(k1) >>> 1))));
			k3 = scale_by_h(slope(xm, sat32(longint'(y_cur) + (longint'(k2) >>> 1))));
			k4 = scale_by_h(slope(xe, sat32(longint'(y_cur) + longint'(k3))));
			s = longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4);
			d = (s >= 0) ? (s + 3) / 6 : (s - 3) / 6;
			y_cur = sat32(longint'(y_cur) + longint'(sat32(d)));
			x_cur = xe;
			step_count = step_count + 16'd1;
		end
		r.x = x_cur;
		r.y = y_cur;
		r.lim = (step_count >= step_cap);
		r.sat = clipped;
		return r;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_EQ_SEL:  eq_sel = data[1:0];
			REG_STEP:    h_step = data[30:0];
			REG_X_START: x_init = data;
			REG_Y_START: y_init = data;
			REG_LIMIT:   step_cap = data[15:0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin : watch
		xy_res_t got, want;
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready) begin
				got = m_tdata[65:0];
				if (expected_xy.size() == 0) begin
					report_mismatch("result with no request", got.y, 0);
				end else begin
					want = expected_xy.pop_front();
					if (got.x !== want.x)
						report_mismatch("x_now", $signed(got.x), $signed(want.x));
					if (got.y !== want.y)
						report_mismatch("y_now", $signed(got.y), $signed(want.y));
					if (got.lim !== want.lim)
						report_mismatch("limit_reached", got.lim, want.lim);
					if (got.sat !== want.sat)
						report_mismatch("saturated", got.sat, want.sat);
				end
			end
			if (s_tvalid && s_tready) begin
				want = rk4_integrate(s_tdata[0]);
				if (item_typed)
					want = item_want;
				expected_xy.push_back(want);
			end
		end
	end

	function automatic plan_row_t wr_row(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		plan_row_t r;
		r = '{ROW_WRITE, idx, data, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic restart);
		plan_row_t r;
		r = '{ROW_ITEM, '0, '0, restart, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic restart, input logic [31:0] x,
			input logic [31:0] y, input logic lim, input logic sat);
		plan_row_t r;
		r = '{ROW_ITEM, '0, '0, restart, 1'b1, '{sat, lim, y, x}};
		return r;
	endfunction

	task automatic send_item(input logic restart, input logic typed, input xy_res_t want);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		item_typed <= typed;
		item_want <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_xy.size() != 0);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_q();
		case ($urandom_range(9))
			0: return Q_HI;
			1: return Q_LO;
			2: return $urandom();
			default: return $urandom_range(1 << 20) - (1 << 19);
		endcase
	endfunction

	function automatic logic [31:0] pick_h();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'd1;
			2: v = $urandom();
			3: v = 32'd0;
			default: v = $urandom_range(1, 131072);
		endcase
		v[31] = 1'($urandom_range(1));
		return v;
	endfunction

	function automatic logic [31:0] pick_limit();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(9))
			0: v[15:0] = 16'd0;
			1: v[15:0] = 16'hFFFF;
			2: v[15:0] = 16'($urandom_range(65535));
			default: v[15:0] = 16'($urandom_range(1, 30));
		endcase
		return v;
	endfunction

	initial begin : stimulus
		int        sent;
		int        run_len;
		logic      in_write;
		logic      well_formed;
		logic [31:0] v;
		plan_row_t row;

		plan.push_back(known_row(1'b1, '0, ONE_Q, 1'b0, 1'b0));
		plan.push_back(item_row(1'b0));
		plan.push_back(item_row(1'b0));
		// limit of zero: restart and step both report the limit
		plan.push_back(wr_row(REG_LIMIT, 32'd0));
		plan.push_back(known_row(1'b1, '0, ONE_Q, 1'b1, 1'b0));
		plan.push_back(known_row(1'b0, '0, ONE_Q, 1'b1, 1'b0));
		// two steps, then held
		plan.push_back(wr_row(REG_LIMIT, 32'd2));
		plan.push_back(known_row(1'b1, '0, ONE_Q, 1'b0, 1'b0));
		plan.push_back(item_row(1'b0));
		plan.push_back(item_row(1'b0));
		plan.push_back(item_row(1'b0));
		// limit lowered below the count already taken
		plan.push_back(wr_row(REG_LIMIT, 32'd1));
		plan.push_back(item_row(1'b0));
		// zero step size still counts but moves nothing
		plan.push_back(wr_row(REG_STEP, 32'd0));
		plan.push_back(wr_row(REG_LIMIT, 32'hFFFF_FFFF));
		plan.push_back(known_row(1'b1, '0, ONE_Q, 1'b0, 1'b0));
		plan.push_back(known_row(1'b0, '0, ONE_Q, 1'b0, 1'b0));
		// top of range
		plan.push_back(wr_row(REG_STEP, 32'hFFFF_FFFF));
		plan.push_back(wr_row(REG_X_START, Q_HI));
		plan.push_back(wr_row(REG_Y_START, Q_HI));
		plan.push_back(known_row(1'b1, Q_HI, Q_HI, 1'b0, 1'b0));
		plan.push_back(item_row(1'b0));
		plan.push_back(wr_row(REG_EQ_SEL, {30'h3FFF_FFFF, EQ_TWO_X}));
		plan.push_back(item_row(1'b1));
		plan.push_back(item_row(1'b0));
		// bottom of range
		plan.push_back(wr_row(REG_X_START, Q_LO));
		plan.push_back(wr_row(REG_Y_START, Q_LO));
		plan.push_back(wr_row(REG_EQ_SEL, {30'd0, EQ_NEG_Y}));
		plan.push_back(known_row(1'b1, Q_LO, Q_LO, 1'b0, 1'b0));
		plan.push_back(item_row(1'b0));
		plan.push_back(wr_row(REG_EQ_SEL, {30'd0, EQ_THREE_M_Y}));
		plan.push_back(item_row(1'b1));
		plan.push_back(item_row(1'b0));
		// spare indexes change nothing
		plan.push_back(wr_row(REG_SPARE, 32'hFFFF_FFFF));
		plan.push_back(wr_row(REG_SPARE + 3'd1, 32'd0));
		plan.push_back(wr_row(REG_SPARE + 3'd2, 32'hA5A5_5A5A));
		plan.push_back(item_row(1'b1));
		plan.push_back(item_row(1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_write = 1'b0;
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				if (!in_write)
					drain();
				cfg_write(row.idx, row.data);
				in_write = 1'b1;
			end else begin
				if (in_write)
					cfg_we <= 1'b0;
				in_write = 1'b0;
				send_item(row.restart, row.typed, row.want);
			end
		end

		sent = 0;
		while (sent < ITEM_COUNT) begin
			drain();
			if ($urandom_range(3) == 0)
				cfg_write(REG_EQ_SEL, {$urandom()} & 32'hFFFF_FFFC | $urandom_range(3));
			if ($urandom_range(2) == 0)
				cfg_write(REG_STEP, pick_h());
			if ($urandom_range(2) == 0)
				cfg_write(REG_X_START, pick_q());
			if ($urandom_range(2) == 0)
				cfg_write(REG_Y_START, pick_q());
			if ($urandom_range(2) == 0)
				cfg_write(REG_LIMIT, pick_limit());
			if ($urandom_range(15) == 0)
				cfg_write(IDX_W'($urandom_range(REG_SPARE, 2**IDX_W - 1)), $urandom());
			cfg_we <= 1'b0;

			quiet = (sent >= 250 && sent < 400);
			idle_pct = quiet ? 0 : 9;
			well_formed = ($urandom_range(99) < 85);
			run_len = $urandom_range(4, 40);
			for (int n = 0; n < run_len; n++) begin
				if (well_formed)
					v[0] = (n == 0) || ($urandom_range(99) < 4);
				else
					v[0] = 1'($urandom_range(1));
				send_item(v[0], 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (expected_xy.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0 && expected_xy.size() == 0) begin
			$display("rk4_ode_stepper_core_tb: done, clean");
		end else begin
			$display("rk4_ode_stepper_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("rk4_ode_stepper_core_tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/rk4_pkg.sv
src/rk4_mul.sv
src/rk4_div6.sv
src/rk4_seq.sv
src/rk4_ode_stepper_core.sv
tb/rk4_ode_stepper_core_tb.sv
